FILE: hdl/brl_pkg.sv
package brl_pkg;

	// output coordinate and canvas register widths are fixed by the interface
	localparam int OUT_BITS       = 10;
	localparam int CANVAS_BITS    = 11;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [CANVAS_BITS-1:0] CANVAS_RESET = 11'd400;

	localparam logic [CFG_INDEX_BITS-1:0] REG_CANVAS_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CANVAS_HEIGHT = 2'd1;

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_ADVANCE = 1'b1
	} opcode_t;

	// both queues hold two entries
	localparam int QUEUE_AW = 1;

	// result word: pixel_x, pixel_y, in_canvas, last
	localparam int RES_BITS = 2 * OUT_BITS + 2;

	typedef struct packed {
		logic cmd_pop;
		logic res_push;
		logic line_active;
	} back_status_t;

endpackage

FILE: hdl/brl_fifo.sv
module brl_fifo #(
	parameter int WIDTH,
	parameter int AW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int DEPTH = 1 << AW;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [AW:0]      count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == (AW + 1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + AW'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (AW + 1)'(1);
				2'b01:   count_q <= count_q - (AW + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hdl/brl_front.sv
module brl_front #(
	parameter int COORD_BITS
) (
	input  logic                                  opcode,
	input  logic [brl_pkg::OUT_BITS-1:0]          start_x,
	input  logic [brl_pkg::OUT_BITS-1:0]          start_y,
	input  logic [brl_pkg::OUT_BITS-1:0]          end_x,
	input  logic [brl_pkg::OUT_BITS-1:0]          end_y,
	output logic [6*COORD_BITS+4:0]               cmd
);

	localparam int ERR_BITS = COORD_BITS + 2;

	logic [COORD_BITS-1:0]      ax, ay, bx, by;
	logic [COORD_BITS-1:0]      dx, dy;
	logic [COORD_BITS-1:0]      sx, sy, ex, ey;
	logic [COORD_BITS-1:0]      major_end;
	logic signed [ERR_BITS-1:0] e0;
	logic                       x_major;
	logic                       swap;
	logic                       minor_dec;
	logic                       is_load;

	always_comb begin
		ax = COORD_BITS'(start_x);
		ay = COORD_BITS'(start_y);
		bx = COORD_BITS'(end_x);
		by = COORD_BITS'(end_y);
		dx = (bx >= ax) ? bx - ax : ax - bx;
		dy = (by >= ay) ? by - ay : ay - by;
		e0 = $signed(ERR_BITS'(dy)) - $signed(ERR_BITS'(dx));
		// equal magnitudes count as y-major, which orders descending diagonals by y
		x_major = e0[ERR_BITS-1];
		swap    = x_major ? (bx < ax) : (by < ay);
		sx = swap ? bx : ax;
		sy = swap ? by : ay;
		ex = swap ? ax : bx;
		ey = swap ? ay : by;
		minor_dec = x_major ? (ey < sy) : (ex < sx);
		major_end = x_major ? ex : ey;
		is_load   = (opcode == brl_pkg::OP_LOAD);
	end

	assign cmd = {is_load, x_major, minor_dec, sx, sy, major_end, dx, dy, e0};

endmodule

FILE: hdl/brl_back.sv
module brl_back #(
	parameter int COORD_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [6*COORD_BITS+4:0]            cmd,
	input  logic                               cmd_empty,
	input  logic                               res_full,
	input  logic [brl_pkg::CANVAS_BITS-1:0]    width_lim,
	input  logic [brl_pkg::CANVAS_BITS-1:0]    height_lim,
	output logic [brl_pkg::RES_BITS-1:0]       result,
	output brl_pkg::back_status_t              status
);

	localparam int ERR_BITS = COORD_BITS + 2;
	localparam int CMP_BITS = (COORD_BITS > brl_pkg::CANVAS_BITS) ?
		COORD_BITS : brl_pkg::CANVAS_BITS;

	logic                       c_load, c_xmaj, c_mdec;
	logic [COORD_BITS-1:0]      c_x, c_y, c_end, c_dx, c_dy;
	logic signed [ERR_BITS-1:0] c_e0;

	logic [COORD_BITS-1:0]      cur_x_q, cur_y_q, major_end_q, dx_q, dy_q;
	logic signed [ERR_BITS-1:0] err_q, diff_q;
	logic                       x_major_q, minor_dec_q, active_q;

	logic [COORD_BITS-1:0]      nxt_x, nxt_y;
	logic signed [ERR_BITS-1:0] nxt_err;
	logic                       fin, in_canvas, minor_step;
	logic                       cmd_pop, res_push;

	assign {c_load, c_xmaj, c_mdec, c_x, c_y, c_end, c_dx, c_dy, c_e0} = cmd;

	assign cmd_pop  = !cmd_empty && !res_full;
	assign res_push = cmd_pop && !c_load && active_q;

	assign fin = x_major_q ? (cur_x_q == major_end_q) : (cur_y_q == major_end_q);
	assign in_canvas = (CMP_BITS'(cur_x_q) < CMP_BITS'(width_lim)) &&
		(CMP_BITS'(cur_y_q) < CMP_BITS'(height_lim));

	// diff_q holds dy - dx, so each step is a single add
	always_comb begin
		nxt_x = cur_x_q;
		nxt_y = cur_y_q;
		if (x_major_q) begin
			minor_step = !err_q[ERR_BITS-1];
			nxt_x = cur_x_q + COORD_BITS'(1);
			if (minor_step) begin
				nxt_y = minor_dec_q ? cur_y_q - COORD_BITS'(1) : cur_y_q + COORD_BITS'(1);
			end
			nxt_err = err_q + (minor_step ? diff_q : $signed(ERR_BITS'(dy_q)));
		end else begin
			minor_step = err_q[ERR_BITS-1] || (err_q == '0);
			nxt_y = cur_y_q + COORD_BITS'(1);
			if (minor_step) begin
				nxt_x = minor_dec_q ? cur_x_q - COORD_BITS'(1) : cur_x_q + COORD_BITS'(1);
			end
			nxt_err = minor_step ? err_q + diff_q : err_q - $signed(ERR_BITS'(dx_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			major_end_q <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			err_q       <= '0;
			diff_q      <= '0;
			x_major_q   <= 1'b0;
			minor_dec_q <= 1'b0;
			active_q    <= 1'b0;
		end else if (cmd_pop) begin
			if (c_load) begin
				cur_x_q     <= c_x;
				cur_y_q     <= c_y;
				major_end_q <= c_end;
				dx_q        <= c_dx;
				dy_q        <= c_dy;
				err_q       <= c_e0;
				diff_q      <= c_e0;
				x_major_q   <= c_xmaj;
				minor_dec_q <= c_mdec;
				active_q    <= 1'b1;
			end else if (active_q) begin
				if (fin) begin
					active_q <= 1'b0;
				end else begin
					cur_x_q <= nxt_x;
					cur_y_q <= nxt_y;
					err_q   <= nxt_err;
				end
			end
		end
	end

	assign result = {brl_pkg::OUT_BITS'(cur_x_q), brl_pkg::OUT_BITS'(cur_y_q), in_canvas, fin};

	assign status.cmd_pop     = cmd_pop;
	assign status.res_push    = res_push;
	assign status.line_active = active_q;

endmodule

FILE: hdl/bresenham_line_rasterizer_top.sv
// channel   direction  handshake              payload
// input     in         push / full            opcode, start_x, start_y, end_x, end_y
// result    out        empty / pop            pixel_x, pixel_y, in_canvas, last
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item per cycle while the command queue has room: a pushed item is classified and
// queued in its cycle, the back end takes one queued command per cycle and emits at most
// one pixel into a two-entry result queue, which registers it for the outputs.
// the back end stalls only while the result queue is full; full rises only while the
// command queue is full. a load never produces a result.
// reset clears both queues, drops any line and sets both canvas sizes to 400.
module bresenham_line_rasterizer_top #(
	parameter int COORD_BITS = 10
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     push,
	output logic                                     full,
	input  logic                                     opcode,
	input  logic [brl_pkg::OUT_BITS-1:0]             start_x,
	input  logic [brl_pkg::OUT_BITS-1:0]             start_y,
	input  logic [brl_pkg::OUT_BITS-1:0]             end_x,
	input  logic [brl_pkg::OUT_BITS-1:0]             end_y,
	output logic                                     empty,
	input  logic                                     pop,
	output logic [brl_pkg::OUT_BITS-1:0]             pixel_x,
	output logic [brl_pkg::OUT_BITS-1:0]             pixel_y,
	output logic                                     in_canvas,
	output logic                                     last,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [brl_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
	input  logic [brl_pkg::CANVAS_BITS-1:0]          cfg_data
);

	localparam int CMD_BITS = 6 * COORD_BITS + 5;

	logic [brl_pkg::CANVAS_BITS-1:0] width_lim_q;
	logic [brl_pkg::CANVAS_BITS-1:0] height_lim_q;

	logic [CMD_BITS-1:0]              cmd_wdata, cmd_rdata;
	logic                             cmd_empty;
	logic [brl_pkg::RES_BITS-1:0]     res_wdata, res_rdata;
	logic                             res_full;
	brl_pkg::back_status_t            status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_lim_q  <= brl_pkg::CANVAS_RESET;
			height_lim_q <= brl_pkg::CANVAS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				brl_pkg::REG_CANVAS_WIDTH:  width_lim_q  <= cfg_data;
				brl_pkg::REG_CANVAS_HEIGHT: height_lim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	brl_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.opcode (opcode),
		.start_x(start_x),
		.start_y(start_y),
		.end_x  (end_x),
		.end_y  (end_y),
		.cmd    (cmd_wdata)
	);

	brl_fifo #(
		.WIDTH(CMD_BITS),
		.AW   (brl_pkg::QUEUE_AW)
	) u_cmd_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cmd_wdata),
		.full  (full),
		.pop   (status.cmd_pop),
		.rdata (cmd_rdata),
		.empty (cmd_empty)
	);

	brl_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_rdata),
		.cmd_empty (cmd_empty),
		.res_full  (res_full),
		.width_lim (width_lim_q),
		.height_lim(height_lim_q),
		.result    (res_wdata),
		.status    (status)
	);

	brl_fifo #(
		.WIDTH(brl_pkg::RES_BITS),
		.AW   (brl_pkg::QUEUE_AW)
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (status.res_push),
		.wdata (res_wdata),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_rdata),
		.empty (empty)
	);

	assign {pixel_x, pixel_y, in_canvas, last} = res_rdata;

`ifndef ASSERT_OFF
	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		status.res_push |-> !res_full)
		else $error("pixel pushed into a full result queue");

	a_cmd_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		status.cmd_pop |-> !cmd_empty)
		else $error("command taken from an empty queue");

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		status.res_push && res_wdata[0] |=> !status.line_active)
		else $error("line still active after its last pixel");
`endif

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int CLK_HALF        = 5;
	localparam int ITEMS_PER_PHASE = 90;
	localparam int NUM_PHASES      = 10;
	localparam int SETTLE_CYCLES   = 8;
	localparam int LIMIT_CYCLES    = 1000000;
	localparam int COORD_MAX       = 1023;

	// index with no register behind it, writes must leave both sizes alone
	localparam logic [brl_pkg::CFG_INDEX_BITS-1:0] REG_UNMAPPED = 2'd2;

	typedef struct packed {
		brl_pkg::opcode_t              op;
		logic [brl_pkg::OUT_BITS-1:0]  sx;
		logic [brl_pkg::OUT_BITS-1:0]  sy;
		logic [brl_pkg::OUT_BITS-1:0]  ex;
		logic [brl_pkg::OUT_BITS-1:0]  ey;
	} line_cmd_t;

	typedef struct packed {
		logic [brl_pkg::OUT_BITS-1:0]  px;
		logic [brl_pkg::OUT_BITS-1:0]  py;
		logic                          visible;
		logic                          fin;
	} pixel_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                push = 1'b0;
	logic                                full;
	logic                                opcode;
	logic [brl_pkg::OUT_BITS-1:0]        start_x;
	logic [brl_pkg::OUT_BITS-1:0]        start_y;
	logic [brl_pkg::OUT_BITS-1:0]        end_x;
	logic [brl_pkg::OUT_BITS-1:0]        end_y;
	logic                                empty;
	logic                                pop = 1'b0;
	logic [brl_pkg::OUT_BITS-1:0]        pixel_x;
	logic [brl_pkg::OUT_BITS-1:0]        pixel_y;
	logic                                in_canvas;
	logic                                last;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [brl_pkg::CFG_INDEX_BITS-1:0]  cfg_index = '0;
	logic [brl_pkg::CANVAS_BITS-1:0]     cfg_data = '0;

	line_cmd_t bus_cmd = '0;

	assign opcode  = bus_cmd.op;
	assign start_x = bus_cmd.sx;
	assign start_y = bus_cmd.sy;
	assign end_x   = bus_cmd.ex;
	assign end_y   = bus_cmd.ey;

	bresenham_line_rasterizer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.opcode    (opcode),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.empty     (empty),
		.pop       (pop),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.in_canvas (in_canvas),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	line_cmd_t cmd_backlog[$];
	pixel_t    pixels_due[$];

	// mirror of the canvas registers and of the line walker
	logic [brl_pkg::CANVAS_BITS-1:0] canvas_w = brl_pkg::CANVAS_RESET;
	logic [brl_pkg::CANVAS_BITS-1:0] canvas_h = brl_pkg::CANVAS_RESET;
	logic [brl_pkg::OUT_BITS-1:0]    walk_x = '0;
	logic [brl_pkg::OUT_BITS-1:0]    walk_y = '0;
	logic [brl_pkg::OUT_BITS-1:0]    walk_end = '0;
	logic [brl_pkg::OUT_BITS-1:0]    walk_dx = '0;
	logic [brl_pkg::OUT_BITS-1:0]    walk_dy = '0;
	int                              walk_err = 0;
	logic                            walk_xmajor = 1'b0;
	logic                            walk_down = 1'b0;
	logic                            walk_active = 1'b0;

	int errors = 0;
	int cycles = 0;
	int loads_sent = 0;
	int pixels_seen = 0;
	int lines_finished = 0;
	int pixels_outside = 0;
	int canvas_writes = 0;
	int phase_budget = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int send_wait = 0;
	int pop_wait = 0;

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d pixels outstanding", $time, pixels_due.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int pick_gap(input int idle_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r >= idle_pct)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [brl_pkg::OUT_BITS-1:0] clamp_coord(input int v);
		int c;
		c = v;
		if (c < 0)
			c = 0;
		if (c > COORD_MAX)
			c = COORD_MAX;
		return c[brl_pkg::OUT_BITS-1:0];
	endfunction

	// coordinates cluster at the origin, the top of the range and the canvas edge
	function automatic logic [brl_pkg::OUT_BITS-1:0] pick_coord(
			input logic [brl_pkg::CANVAS_BITS-1:0] edge_at);
		int v;
		case ($urandom_range(0, 4))
			0: v = $urandom_range(0, 15);
			1: v = $urandom_range(COORD_MAX - 15, COORD_MAX);
			2: v = int'(edge_at) + int'($urandom_range(0, 16)) - 8;
			default: v = $urandom_range(0, COORD_MAX);
		endcase
		return clamp_coord(v);
	endfunction

	function automatic int abs_diff(input logic [brl_pkg::OUT_BITS-1:0] a,
			input logic [brl_pkg::OUT_BITS-1:0] b);
		return (a >= b) ? int'(a - b) : int'(b - a);
	endfunction

	// walks the line one item at a time and queues the pixel it should emit
	task automatic rasterize(input line_cmd_t c);
		logic [brl_pkg::OUT_BITS-1:0] ax, ay, bx, by, t;
		logic                         swap;
		logic                         done;
		int                           dxi, dyi;
		pixel_t                       p;
		if (c.op == brl_pkg::OP_LOAD) begin
			ax = c.sx;
			ay = c.sy;
			bx = c.ex;
			by = c.ey;
			walk_dx = (bx >= ax) ? bx - ax : ax - bx;
			walk_dy = (by >= ay) ? by - ay : ay - by;
			dxi = int'(walk_dx);
			dyi = int'(walk_dy);
			walk_err = dyi - dxi;
			walk_xmajor = (walk_err < 0);
			swap = walk_xmajor ? (bx < ax) : (by < ay);
			if (swap) begin
				t = ax;
				ax = bx;
				bx = t;
				t = ay;
				ay = by;
				by = t;
			end
			walk_x = ax;
			walk_y = ay;
			if (walk_xmajor) begin
				walk_end = bx;
				walk_down = (by < ay);
			end else begin
				walk_end = by;
				walk_down = (bx < ax);
			end
			walk_active = 1'b1;
			loads_sent++;
		end else if (walk_active) begin
			dxi = int'(walk_dx);
			dyi = int'(walk_dy);
			done = walk_xmajor ? (walk_x == walk_end) : (walk_y == walk_end);
			p.px = walk_x;
			p.py = walk_y;
			p.visible = ({1'b0, walk_x} < canvas_w) && ({1'b0, walk_y} < canvas_h);
			p.fin = done;
			pixels_due.insert(pixels_due.size(), p);
			if (done) begin
				walk_active = 1'b0;
			end else if (walk_xmajor) begin
				if (walk_err >= 0) begin
					walk_y = walk_down ? walk_y - 1'b1 : walk_y + 1'b1;
					walk_err -= dxi;
				end
				walk_err += dyi;
				walk_x = walk_x + 1'b1;
			end else begin
				if (walk_err <= 0) begin
					walk_x = walk_down ? walk_x - 1'b1 : walk_x + 1'b1;
					walk_err += dyi;
				end
				walk_err -= dxi;
				walk_y = walk_y + 1'b1;
			end
		end
	endtask

	// sender: one transfer per accepted item, random gaps between items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			send_wait = 0;
		end else begin
			if (push && !full) begin
				rasterize(bus_cmd);
				send_wait = pick_gap(tx_idle_pct);
			end
			if (push && full) begin
				// hold the item until it is taken
			end else if (send_wait > 0) begin
				send_wait--;
				push <= 1'b0;
			end else if (cmd_backlog.size() > 0) begin
				bus_cmd <= cmd_backlog.pop_front();
				push <= 1'b1;
			end else begin
				push <= 1'b0;
			end
		end
	end

	function automatic void check_field(input string name,
			input logic [brl_pkg::OUT_BITS-1:0] want,
			input logic [brl_pkg::OUT_BITS-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// receiver: compares every popped pixel with the oldest one still due
	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			pop <= 1'b0;
			pop_wait = 0;
		end else begin
			if (pop && !empty) begin
				pixels_seen++;
				if (pixels_due.size() == 0) begin
					$display("%0t: pixel (%0d,%0d) popped with none expected, expected nothing",
						$time, pixel_x, pixel_y);
					errors++;
				end else begin
					want = pixels_due.pop_front();
					check_field("pixel_x", want.px, pixel_x);
					check_field("pixel_y", want.py, pixel_y);
					check_field("in_canvas", brl_pkg::OUT_BITS'(want.visible),
						brl_pkg::OUT_BITS'(in_canvas));
					check_field("last", brl_pkg::OUT_BITS'(want.fin),
						brl_pkg::OUT_BITS'(last));
					if (want.fin)
						lines_finished++;
					if (!want.visible)
						pixels_outside++;
				end
				pop_wait = pick_gap(rx_idle_pct);
			end
			if (pop_wait > 0) begin
				pop_wait--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic queue_cmd(input brl_pkg::opcode_t op, input int sx, input int sy,
			input int ex, input int ey);
		line_cmd_t c;
		c.op = op;
		c.sx = sx[brl_pkg::OUT_BITS-1:0];
		c.sy = sy[brl_pkg::OUT_BITS-1:0];
		c.ex = ex[brl_pkg::OUT_BITS-1:0];
		c.ey = ey[brl_pkg::OUT_BITS-1:0];
		cmd_backlog.insert(cmd_backlog.size(), c);
	endtask

	// endpoint fields are don't-care on an advance, so they carry noise
	task automatic queue_advances(input int n);
		repeat (n)
			queue_cmd(brl_pkg::OP_ADVANCE, $urandom_range(0, COORD_MAX),
				$urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
				$urandom_range(0, COORD_MAX));
	endtask

	// one load followed by its advances, sometimes cut short or overrun
	task automatic queue_line();
		logic [brl_pkg::OUT_BITS-1:0] sx, sy, ex, ey;
		int                           span, d, n, k, r;
		sx = pick_coord(canvas_w);
		sy = pick_coord(canvas_h);
		r = $urandom_range(0, 99);
		span = (r < 70) ? 8 : (r < 97) ? 64 : 0;
		if (span == 0) begin
			ex = clamp_coord($urandom_range(0, COORD_MAX));
			ey = clamp_coord($urandom_range(0, COORD_MAX));
		end else begin
			ex = clamp_coord(int'(sx) + int'($urandom_range(0, 2 * span)) - span);
			ey = clamp_coord(int'(sy) + int'($urandom_range(0, 2 * span)) - span);
		end
		// diagonal lines, rising and falling
		if ($urandom_range(0, 9) == 0) begin
			d = abs_diff(ex, sx);
			if ($urandom_range(0, 1) && int'(sy) >= d)
				ey = clamp_coord(int'(sy) - d);
			else if (int'(sy) + d <= COORD_MAX)
				ey = clamp_coord(int'(sy) + d);
			else
				ey = clamp_coord(int'(sy) - d);
		end
		n = ((abs_diff(ex, sx) > abs_diff(ey, sy)) ? abs_diff(ex, sx) : abs_diff(ey, sy)) + 1;
		r = $urandom_range(0, 99);
		k = (r < 10) ? $urandom_range(0, n - 1) : n;
		// long lines are cut where the phase runs out of items
		if (k > phase_budget - 1)
			k = phase_budget - 1;
		queue_cmd(brl_pkg::OP_LOAD, int'(sx), int'(sy), int'(ex), int'(ey));
		queue_advances(k);
		phase_budget -= 1 + k;
		if (r >= 90)
			queue_advances($urandom_range(1, 3));
	endtask

	task automatic write_reg(input logic [brl_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [brl_pkg::CANVAS_BITS-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		canvas_writes++;
		if (idx == brl_pkg::REG_CANVAS_WIDTH)
			canvas_w = val;
		else if (idx == brl_pkg::REG_CANVAS_HEIGHT)
			canvas_h = val;
	endtask

	// waits until every queued item is sent, every due pixel is back and the pipe has emptied
	task automatic wait_drained();
		while (cmd_backlog.size() > 0 || push || pixels_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	initial begin
		int plan_w[6];
		int plan_h[6];
		int w, h;
		plan_w = '{0, 2047, 1, 1024, 400, 37};
		plan_h = '{1024, 0, 1, 1024, 1, 1023};

		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lines under the reset canvas
		tx_idle_pct = 20;
		rx_idle_pct = 20;
		queue_cmd(brl_pkg::OP_ADVANCE, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		queue_cmd(brl_pkg::OP_LOAD, 0, 0, 0, 0);
		queue_advances(1);
		queue_cmd(brl_pkg::OP_LOAD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		queue_advances(1);
		queue_cmd(brl_pkg::OP_LOAD, 3, 0, 0, 3);
		queue_advances(4);
		queue_cmd(brl_pkg::OP_LOAD, 0, 1, 3, 0);
		queue_advances(4);
		queue_cmd(brl_pkg::OP_LOAD, COORD_MAX, 0, 0, COORD_MAX);
		queue_advances(2);
		queue_cmd(brl_pkg::OP_LOAD, 512, 511, 512, 511);
		queue_advances(1);
		queue_cmd(brl_pkg::OP_ADVANCE, 0, 0, 0, 0);
		wait_drained();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph < 6) begin
				w = plan_w[ph];
				h = plan_h[ph];
			end else begin
				w = $urandom_range(1, 1024);
				h = $urandom_range(1, 1024);
			end
			if ($urandom_range(0, 1)) begin
				write_reg(brl_pkg::REG_CANVAS_WIDTH, w[brl_pkg::CANVAS_BITS-1:0]);
				write_reg(brl_pkg::REG_CANVAS_HEIGHT, h[brl_pkg::CANVAS_BITS-1:0]);
			end else begin
				write_reg(brl_pkg::REG_CANVAS_HEIGHT, h[brl_pkg::CANVAS_BITS-1:0]);
				write_reg(brl_pkg::REG_CANVAS_WIDTH, w[brl_pkg::CANVAS_BITS-1:0]);
			end
			if (ph == 3)
				write_reg(REG_UNMAPPED, '1);

			// no idling, light idling, receiver backpressure, slow sender
			case (ph % 4)
				0: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
				1: begin
					tx_idle_pct = 30;
					rx_idle_pct = 30;
				end
				2: begin
					tx_idle_pct = 0;
					rx_idle_pct = 70;
				end
				default: begin
					tx_idle_pct = 60;
					rx_idle_pct = 10;
				end
			endcase

			phase_budget = ITEMS_PER_PHASE;
			while (phase_budget > 0) begin
				if ($urandom_range(0, 99) < 5)
					queue_cmd(brl_pkg::opcode_t'($urandom_range(0, 1)),
						$urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
						$urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
				else
					queue_line();
			end
			wait_drained();
		end

		$display("%0d lines loaded over %0d canvas writes, %0d pixels checked",
			loads_sent, canvas_writes, pixels_seen);
		$display("%0d lines ended with last, %0d pixels clipped off the canvas",
			lines_finished, pixels_outside);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/brl_pkg.sv
hdl/brl_fifo.sv
hdl/brl_front.sv
hdl/brl_back.sv
hdl/bresenham_line_rasterizer_top.sv
dv/testbench.sv
